// File: hw/rtl/lsur_pkg.sv
// shared types, codes and microcode tables for the lifo stack with unique readout
package lsur_pkg;

	// request and status codes
	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_LIST = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	// microprogram steps
	typedef enum logic [3:0] {
		ST_IDLE      = 4'd0,
		ST_PUSH_OK   = 4'd1,
		ST_PUSH_FULL = 4'd2,
		ST_EMPTY     = 4'd3,
		ST_POP_OUT   = 4'd4,
		ST_L_CAND    = 4'd5,
		ST_L_CMP     = 4'd6,
		ST_L_HIT     = 4'd7,
		ST_L_EMIT    = 4'd8,
		ST_L_NEXT    = 4'd9,
		ST_L_FIN     = 4'd10
	} step_t;

	typedef enum logic [2:0] {
		C_NONE     = 3'd0,
		C_DISPATCH = 3'd1,
		C_MATCH    = 3'd2,
		C_J_EQ_I   = 3'd3,
		C_I_ZERO   = 3'd4
	} cond_t;

	typedef enum logic [2:0] {
		E_NONE      = 3'd0,
		E_OK        = 3'd1,
		E_FULL      = 3'd2,
		E_EMPTY     = 3'd3,
		E_RDATA     = 3'd4,
		E_PEND_MID  = 3'd5,
		E_PEND_LAST = 3'd6
	} emit_t;

	typedef enum logic [1:0] {
		RA_TOP  = 2'd0,
		RA_J_M1 = 2'd1,
		RA_I_M1 = 2'd2
	} ra_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2
	} cnt_op_t;

	typedef enum logic [1:0] {
		I_HOLD   = 2'd0,
		I_TOP    = 2'd1,
		I_DEC_NZ = 2'd2
	} i_op_t;

	typedef enum logic [1:0] {
		J_HOLD     = 2'd0,
		J_TOP      = 2'd1,
		J_DEC_MISS = 2'd2
	} j_op_t;

	// one control word
	typedef struct packed {
		logic    take;
		cond_t   cond;
		step_t   jmp;
		step_t   nxt;
		emit_t   emit;
		logic    re;
		ra_t     ra;
		logic    we;
		cnt_op_t cnt_op;
		i_op_t   i_op;
		j_op_t   j_op;
		logic    w_ld;
		logic    pend_ld;
		logic    pend_clr;
	} ctl_t;

	// datapath flags back to the sequencer
	typedef struct packed {
		logic hold;
		logic full;
		logic empty;
		logic match;
		logic j_eq_i;
		logic i_zero;
	} flags_t;

	// control store
	function automatic ctl_t ucode(input step_t st);
		ctl_t c;
		c = '0;
		c.nxt = ST_IDLE;
		c.jmp = ST_IDLE;
		unique case (st)
			ST_IDLE: begin
				c.take     = 1'b1;
				c.cond     = C_DISPATCH;
				c.re       = 1'b1;
				c.ra       = RA_TOP;
				c.i_op     = I_TOP;
				c.pend_clr = 1'b1;
			end
			ST_PUSH_OK: begin
				c.emit   = E_OK;
				c.we     = 1'b1;
				c.cnt_op = CNT_INC;
			end
			ST_PUSH_FULL: begin
				c.emit = E_FULL;
			end
			ST_EMPTY: begin
				c.emit = E_EMPTY;
			end
			ST_POP_OUT: begin
				c.emit   = E_RDATA;
				c.cnt_op = CNT_DEC;
			end
			ST_L_CAND: begin
				c.nxt  = ST_L_CMP;
				c.re   = 1'b1;
				c.ra   = RA_TOP;
				c.j_op = J_TOP;
				c.w_ld = 1'b1;
			end
			ST_L_CMP: begin
				c.cond = C_MATCH;
				c.jmp  = ST_L_HIT;
				c.nxt  = ST_L_CMP;
				c.re   = 1'b1;
				c.ra   = RA_J_M1;
				c.j_op = J_DEC_MISS;
			end
			ST_L_HIT: begin
				c.cond = C_J_EQ_I;
				c.jmp  = ST_L_EMIT;
				c.nxt  = ST_L_NEXT;
			end
			ST_L_EMIT: begin
				c.nxt     = ST_L_NEXT;
				c.emit    = E_PEND_MID;
				c.pend_ld = 1'b1;
			end
			ST_L_NEXT: begin
				c.cond = C_I_ZERO;
				c.jmp  = ST_L_FIN;
				c.nxt  = ST_L_CAND;
				c.re   = 1'b1;
				c.ra   = RA_I_M1;
				c.i_op = I_DEC_NZ;
			end
			ST_L_FIN: begin
				c.emit = E_PEND_LAST;
			end
			default: begin
				c.nxt = ST_IDLE;
			end
		endcase
		return c;
	endfunction

	// entry point of each request
	function automatic step_t dispatch(input logic [1:0] act, input logic full,
			input logic empty);
		step_t s;
		unique case (act)
			ACT_PUSH: s = full ? ST_PUSH_FULL : ST_PUSH_OK;
			ACT_POP:  s = empty ? ST_EMPTY : ST_POP_OUT;
			ACT_LIST: s = empty ? ST_EMPTY : ST_L_CAND;
			default:  s = ST_IDLE;
		endcase
		return s;
	endfunction

endpackage

// File: hw/rtl/lsur_ram.sv
// generic single write port ram with registered read
module lsur_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/lsur_seq.sv
// microprogram sequencer: step counter, control store lookup and jumps
module lsur_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      action,
	input  lsur_pkg::flags_t flags,
	output lsur_pkg::ctl_t  ctl,
	output logic            in_acc,
	output logic            in_stall
);

	lsur_pkg::step_t upc_q;
	lsur_pkg::step_t upc_d;

	assign ctl      = lsur_pkg::ucode(upc_q);
	assign in_acc   = in_valid && ctl.take;
	assign in_stall = !ctl.take;

	always_comb begin
		priority if (flags.hold) begin
			upc_d = upc_q;
		end else begin
			unique case (ctl.cond)
				lsur_pkg::C_NONE:     upc_d = ctl.nxt;
				lsur_pkg::C_DISPATCH: upc_d = in_acc ?
					lsur_pkg::dispatch(action, flags.full, flags.empty) : ctl.nxt;
				lsur_pkg::C_MATCH:    upc_d = flags.match ? ctl.jmp : ctl.nxt;
				lsur_pkg::C_J_EQ_I:   upc_d = flags.j_eq_i ? ctl.jmp : ctl.nxt;
				lsur_pkg::C_I_ZERO:   upc_d = flags.i_zero ? ctl.jmp : ctl.nxt;
				default:              upc_d = ctl.nxt;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= lsur_pkg::ST_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// File: hw/rtl/lsur_dp.sv
// datapath: stack store, count, scan indices, candidate and output register
module lsur_dp #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lsur_pkg::ctl_t          ctl,
	input  logic                    in_acc,
	input  logic signed [31:0]      push_value,
	output lsur_pkg::flags_t        flags,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      word,
	output logic [1:0]              status,
	output logic                    last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        i_q;
	logic [AW-1:0]        j_q;
	logic [WORD_BITS-1:0] w_q;
	logic [WORD_BITS-1:0] pend_q;
	logic                 pend_v_q;
	logic [31:0]          val_q;

	logic                 ovalid_q;
	logic [31:0]          oword_q;
	logic [1:0]           ostatus_q;
	logic                 olast_q;

	logic [AW-1:0]        cnt_m1;
	logic [AW-1:0]        raddr;
	logic [WORD_BITS-1:0] rdata;
	logic [63:0]          rd_ext;
	logic [63:0]          pend_ext;
	logic                 need_emit;
	logic                 out_free;
	logic                 go;

	assign cnt_m1   = AW'(cnt_q - CW'(1));
	assign rd_ext   = 64'(rdata);
	assign pend_ext = 64'(pend_q);
	assign out_free = !ovalid_q || !out_stall;

	// the mid-listing emit only fires once a pending word exists
	assign need_emit = (ctl.emit != lsur_pkg::E_NONE) &&
		!((ctl.emit == lsur_pkg::E_PEND_MID) && !pend_v_q);
	assign go = !(need_emit && !out_free);

	assign flags.hold   = !go;
	assign flags.full   = (cnt_q == CW'(DEPTH));
	assign flags.empty  = (cnt_q == '0);
	assign flags.match  = (rdata == w_q);
	assign flags.j_eq_i = (j_q == i_q);
	assign flags.i_zero = (i_q == '0);

	always_comb begin
		unique case (ctl.ra)
			lsur_pkg::RA_TOP:  raddr = cnt_m1;
			lsur_pkg::RA_J_M1: raddr = j_q - AW'(1);
			lsur_pkg::RA_I_M1: raddr = i_q - AW'(1);
			default:           raddr = cnt_m1;
		endcase
	end

	lsur_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ctl.we && go),
		.waddr (cnt_q[AW-1:0]),
		.wdata (WORD_BITS'(val_q)),
		.re    (ctl.re && go),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			pend_v_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (go) begin
				unique case (ctl.cnt_op)
					lsur_pkg::CNT_INC: cnt_q <= cnt_q + CW'(1);
					lsur_pkg::CNT_DEC: cnt_q <= cnt_q - CW'(1);
					default:           cnt_q <= cnt_q;
				endcase
				unique case (ctl.i_op)
					lsur_pkg::I_TOP:    i_q <= cnt_m1;
					lsur_pkg::I_DEC_NZ: if (!flags.i_zero) i_q <= i_q - AW'(1);
					default:            i_q <= i_q;
				endcase
				unique case (ctl.j_op)
					lsur_pkg::J_TOP:      j_q <= cnt_m1;
					lsur_pkg::J_DEC_MISS: if (!flags.match) j_q <= j_q - AW'(1);
					default:              j_q <= j_q;
				endcase
				if (ctl.pend_clr) begin
					pend_v_q <= 1'b0;
				end else if (ctl.pend_ld) begin
					pend_v_q <= 1'b1;
				end
			end
			if (need_emit && out_free) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q <= push_value;
		end
		if (go && ctl.w_ld) begin
			w_q <= rdata;
		end
		if (go && ctl.pend_ld) begin
			pend_q <= w_q;
		end
		if (need_emit && out_free) begin
			unique case (ctl.emit)
				lsur_pkg::E_FULL: begin
					oword_q   <= '0;
					ostatus_q <= lsur_pkg::STS_FULL;
					olast_q   <= 1'b1;
				end
				lsur_pkg::E_EMPTY: begin
					oword_q   <= '0;
					ostatus_q <= lsur_pkg::STS_EMPTY;
					olast_q   <= 1'b1;
				end
				lsur_pkg::E_RDATA: begin
					oword_q   <= rd_ext[31:0];
					ostatus_q <= lsur_pkg::STS_OK;
					olast_q   <= 1'b1;
				end
				lsur_pkg::E_PEND_MID: begin
					oword_q   <= pend_ext[31:0];
					ostatus_q <= lsur_pkg::STS_OK;
					olast_q   <= 1'b0;
				end
				lsur_pkg::E_PEND_LAST: begin
					oword_q   <= pend_ext[31:0];
					ostatus_q <= lsur_pkg::STS_OK;
					olast_q   <= 1'b1;
				end
				default: begin
					oword_q   <= '0;
					ostatus_q <= lsur_pkg::STS_OK;
					olast_q   <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign word      = $signed(oword_q);
	assign status    = ostatus_q;
	assign last      = olast_q;

endmodule

// File: hw/rtl/lifo_stack_unique_readout.sv
// top level: bounded lifo stack of signed words with push, pop and unique listing
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------
//  in      | in_valid / in_stall | action, push_value
//  out     | out_valid/out_stall | word, status, last
//
// push and pop are served one request at a time; a request of an unused code is taken without a reply.
// a listing scans the stack store, which has one read port, so each candidate is compared with the
// words above it one per cycle.
// reset clears the word count and the sequencer; store contents are left as they are.
// a stalled output holds the sequencer on its emitting step; in_stall stays high meanwhile.
module lifo_stack_unique_readout #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] word,
	output logic [1:0]         status,
	output logic               last
);

	lsur_pkg::ctl_t   ctl;
	lsur_pkg::flags_t flags;
	logic             in_acc;

	lsur_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.flags    (flags),
		.ctl      (ctl),
		.in_acc   (in_acc),
		.in_stall (in_stall)
	);

	lsur_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.in_acc     (in_acc),
		.push_value (push_value),
		.flags      (flags),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.word       (word),
		.status     (status),
		.last       (last)
	);

endmodule

// File: hw/rtl/lsur_chk.sv
// port-level checks for the lifo stack with unique readout, bound to the top level
module lsur_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         action,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] word,
	input logic [1:0]         status,
	input logic               last
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word) && $stable(status) &&
			$stable(last))
		else $error("stalled output word changed");

	// error results carry a zero word and end the request
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == lsur_pkg::STS_FULL || status == lsur_pkg::STS_EMPTY)
			|-> word == 32'sd0 && last)
		else $error("error result with nonzero word or without last");

	// only defined status codes ever appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == lsur_pkg::STS_OK || status == lsur_pkg::STS_FULL ||
			status == lsur_pkg::STS_EMPTY)
		else $error("undefined status code");

	// a real request keeps the input side busy on the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == lsur_pkg::ACT_PUSH ||
			action == lsur_pkg::ACT_POP || action == lsur_pkg::ACT_LIST) |=> in_stall)
		else $error("new word taken while a request is in progress");

endmodule

bind lifo_stack_unique_readout lsur_chk u_chk (.*);

// File: test/lifo_stack_unique_readout_test.sv
// testbench for the lifo stack with unique readout: queued requests, predicted replies
`timescale 1ns / 100ps

module lifo_stack_unique_readout_test;

	localparam int DEPTH = 64;
	localparam int LIMIT = 2000000;
	localparam int LONG_HOLD = 300;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic               drain;
		logic [1:0]         act;
		logic signed [31:0] val;
	} req_t;

	typedef struct packed {
		logic signed [31:0] word;
		logic [1:0]         status;
		logic               last;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         action = lsur_pkg::ACT_PUSH;
	logic signed [31:0] push_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] word;
	logic [1:0]         status;
	logic               last;

	lifo_stack_unique_readout dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word(word),
		.status(status),
		.last(last)
	);

	always #10 clk = ~clk;

	req_t   req_q[$];
	reply_t expected_replies[$];

	// predictor state
	logic signed [31:0] stack_mem [DEPTH];
	int depth_now = 0;
	int depth_peak = 0;

	int cycles = 0;
	int accepted_cnt = 0;
	int n_reqs = 0;
	int press_at = 0;
	int phase_len = 1;
	int bad_cnt = 0;
	int words_checked = 0;
	int refused_seen = 0;
	int listings = 0;
	bit in_fire = 1'b0;
	bit drain_wait = 1'b0;
	int hold_state = 0;
	int hold_left = 0;
	int depth_est = 0;

	function automatic void stack_apply(input logic [1:0] act, input logic signed [31:0] val);
		reply_t r;
		bit seen;
		r = '{word: '0, status: lsur_pkg::STS_OK, last: 1'b1};
		case (act)
			lsur_pkg::ACT_PUSH: begin
				if (depth_now >= DEPTH) begin
					r.status = lsur_pkg::STS_FULL;
				end else begin
					stack_mem[depth_now] = val;
					depth_now++;
					if (depth_now > depth_peak)
						depth_peak = depth_now;
				end
				expected_replies.push_back(r);
			end
			lsur_pkg::ACT_POP: begin
				if (depth_now == 0) begin
					r.status = lsur_pkg::STS_EMPTY;
				end else begin
					depth_now--;
					r.word = stack_mem[depth_now];
				end
				expected_replies.push_back(r);
			end
			lsur_pkg::ACT_LIST: begin
				listings++;
				if (depth_now == 0) begin
					r.status = lsur_pkg::STS_EMPTY;
					expected_replies.push_back(r);
				end else begin
					// top down, a word goes out only where no copy sits above it
					for (int i = depth_now - 1; i >= 0; i--) begin
						seen = 1'b0;
						for (int j = depth_now - 1; j > i; j--)
							if (stack_mem[j] == stack_mem[i])
								seen = 1'b1;
						if (!seen) begin
							r = '{word: stack_mem[i], status: lsur_pkg::STS_OK,
								last: 1'b0};
							expected_replies.push_back(r);
						end
					end
					expected_replies[expected_replies.size() - 1].last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		bad_cnt++;
		$display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, want, got);
	endtask

	function automatic int tx_idle_pct();
		case (accepted_cnt / phase_len)
			0: return 33;
			1: return 45;
			default: return 0;
		endcase
	endfunction

	function automatic int rx_idle_pct();
		case (accepted_cnt / phase_len)
			0: return 45;
			1: return 33;
			default: return 0;
		endcase
	endfunction

	// input acceptance, reply checking and the watchdog
	always @(posedge clk) begin
		reply_t e;
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycles,
				expected_replies.size());
			$display("lifo_stack_unique_readout_test: FAIL");
			$finish;
		end else begin
			in_fire = arst_n && in_valid && !in_stall;
			if (in_fire) begin
				stack_apply(action, push_value);
				accepted_cnt++;
			end
			if (arst_n && out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected word, word", '0, word);
				end else begin
					e = expected_replies.pop_front();
					words_checked++;
					if (status == lsur_pkg::STS_FULL)
						refused_seen++;
					if (word !== e.word)
						report_mismatch("word", e.word, word);
					if (status !== e.status)
						report_mismatch("status", {30'd0, e.status}, {30'd0, status});
					if (last !== e.last)
						report_mismatch("last", {31'd0, e.last}, {31'd0, last});
				end
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		req_t r;
		if (arst_n && (!in_valid || in_fire)) begin
			if (drain_wait) begin
				in_valid <= 1'b0;
				if (expected_replies.size() == 0)
					drain_wait = 1'b0;
			end else if (req_q.size() > 0 && req_q[0].drain) begin
				r = req_q.pop_front();
				drain_wait = 1'b1;
				in_valid <= 1'b0;
			end else if (req_q.size() > 0 && $urandom_range(99) >= tx_idle_pct()) begin
				r = req_q.pop_front();
				in_valid <= 1'b1;
				action <= r.act;
				push_value <= r.val;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// reply side stall, with one long hold-off at the start of the fill
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_state == 0 && accepted_cnt > press_at) begin
				hold_state = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_state == 1) begin
				out_stall <= 1'b1;
				hold_left--;
				if (hold_left == 0)
					hold_state = 2;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct());
			end
		end
	end

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return -32'sd1;
			3: return 32'sd0;
			4: return 32'sh00000001 << $urandom_range(31);
			5: return 32'sh5a5a5a5a;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(input logic [1:0] act, input logic signed [31:0] val);
		req_q.push_back('{drain: 1'b0, act: act, val: val});
		n_reqs++;
		case (act)
			lsur_pkg::ACT_PUSH: if (depth_est < DEPTH) depth_est++;
			lsur_pkg::ACT_POP: if (depth_est > 0) depth_est--;
			default: begin
			end
		endcase
	endtask

	task automatic add_pause();
		req_q.push_back('{drain: 1'b1, act: lsur_pkg::ACT_PUSH, val: '0});
	endtask

	initial begin
		int r;
		logic [1:0] act;

		// directed: empty cases, spare code, extremes, duplicates in a listing
		add_req(lsur_pkg::ACT_POP, 32'sd5);
		add_req(lsur_pkg::ACT_LIST, -32'sd1);
		add_req(ACT_SPARE, 32'sh12345678);
		add_req(lsur_pkg::ACT_PUSH, 32'sh7fffffff);
		add_req(lsur_pkg::ACT_PUSH, 32'sh80000000);
		add_req(lsur_pkg::ACT_PUSH, -32'sd1);
		add_req(lsur_pkg::ACT_PUSH, 32'sd0);
		add_req(lsur_pkg::ACT_PUSH, 32'sh7fffffff);
		add_req(lsur_pkg::ACT_PUSH, -32'sd1);
		add_req(lsur_pkg::ACT_LIST, 32'sd0);
		add_req(ACT_SPARE, -32'sd1);
		add_req(lsur_pkg::ACT_POP, -32'sd1);
		add_req(lsur_pkg::ACT_POP, 32'sd0);
		add_req(lsur_pkg::ACT_LIST, 32'sh7fffffff);
		for (int i = 0; i < 5; i++)
			add_req(lsur_pkg::ACT_POP, $urandom);
		add_pause();

		// fill past full under a long reply hold-off, list the full stack, then empty it
		press_at = n_reqs;
		for (int i = 0; i < DEPTH + 2; i++)
			add_req(lsur_pkg::ACT_PUSH, ($urandom_range(1) != 0) ? pick_word() : $urandom);
		add_req(lsur_pkg::ACT_LIST, $urandom);
		for (int i = 0; i < DEPTH + 1; i++)
			add_req(lsur_pkg::ACT_POP, $urandom);
		add_req(lsur_pkg::ACT_LIST, $urandom);
		add_pause();

		// random mix kept mostly shallow so listings stay short
		depth_est = 0;
		for (int i = 0; i < 100; i++) begin
			r = $urandom_range(99);
			if (r < 3)
				act = ACT_SPARE;
			else if (r < ((depth_est > 16) ? 5 : 13))
				act = lsur_pkg::ACT_LIST;
			else if (depth_est < 4)
				act = ($urandom_range(99) < 70) ? lsur_pkg::ACT_PUSH : lsur_pkg::ACT_POP;
			else if (depth_est > 20)
				act = ($urandom_range(99) < 30) ? lsur_pkg::ACT_PUSH : lsur_pkg::ACT_POP;
			else
				act = $urandom_range(1) ? lsur_pkg::ACT_PUSH : lsur_pkg::ACT_POP;
			add_req(act, pick_word());
			if (i == 50)
				add_pause();
		end
		phase_len = n_reqs / 3;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		while (accepted_cnt < n_reqs || expected_replies.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("ran %0d requests incl. %0d listings, checked %0d replies in %0d cycles",
			accepted_cnt, listings, words_checked, cycles);
		$display("stack reached depth %0d, %0d pushes refused as full, %0d mismatches",
			depth_peak, refused_seen, bad_cnt);
		if (bad_cnt == 0 && expected_replies.size() == 0) begin
			$display("lifo_stack_unique_readout_test: PASS");
		end else begin
			$display("lifo_stack_unique_readout_test: FAIL");
		end
		$finish;
	end

endmodule
